// ===== rtl/counting_semaphore_wait_stack_macros.svh =====
// Assertion helpers used by the semaphore RTL.
// Each macro expects clk and rst_n to exist in the enclosing module.
`ifndef COUNTING_SEMAPHORE_WAIT_STACK_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_STACK_MACROS_SVH

// Condition must never be true outside reset
`define CSWS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Same-cycle implication
`define CSWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CSWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/csws_pkg.sv =====
`timescale 1ns / 1ps

package csws_pkg;

  // Payload field widths
  localparam int OP_W     = 1;
  localparam int PID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Parameter defaults
  localparam int WAIT_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 16;

  // Request kinds
  localparam logic [OP_W-1:0] OP_WAIT   = 1'b0;
  localparam logic [OP_W-1:0] OP_SIGNAL = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SIGNALED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WOKE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER_MAX = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 2'd1;

  // Shift command broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ===== rtl/csws_if.sv =====
`timescale 1ns / 1ps

// Request channel: wait or signal, tagged with a process id
interface csws_req_if;
  logic                          valid;
  logic                          ready;
  logic [csws_pkg::OP_W-1:0]     operation;
  logic [csws_pkg::PID_W-1:0]    pid;

  modport source (output valid, output operation, output pid, input ready);
  modport sink   (input valid, input operation, input pid, output ready);
endinterface

// Result channel: status and woken process id
interface csws_res_if;
  logic                          valid;
  logic                          ready;
  logic [csws_pkg::STATUS_W-1:0] status;
  logic [csws_pkg::PID_W-1:0]    woken_pid;

  modport source (output valid, output status, output woken_pid, input ready);
  modport sink   (input valid, input status, input woken_pid, output ready);
endinterface

// ===== rtl/counting_semaphore_wait_stack.sv =====
`timescale 1ns / 1ps

// Counting semaphore with a LIFO waiter stack.
// in_req carries wait/signal requests with a process id; every accepted
// request yields exactly one transfer on out_res (status, woken_pid).
// The waiter stack is a row of WAIT_DEPTH cells; the top is always cell 0,
// and a push or pop shifts every cell one place toward or away from it.
// The result is registered, valid in the cycle after the request transfer.
// Throughput: one request per cycle while out_res is not stalled; the whole
// decision (count compare, stack shift) completes in the accepting cycle.
// A stalled receiver holds the result in the output register; in_req.ready
// drops only while that register is full and out_res.ready is low.
// cfg_we/cfg_index/cfg_wdata write the start count (loaded at once) and
// limit; the user must write only while the block is idle, unenforced.
// Reset (rst_n low, synchronous): count 0, limit 1, stack empty, no
// result pending. Stack entries are not cleared, only the depth is.
module counting_semaphore_wait_stack #(
  parameter int WAIT_DEPTH = csws_pkg::WAIT_DEPTH_DEF,
  parameter int PID_BITS   = csws_pkg::PID_BITS_DEF,
  parameter int COUNT_BITS = csws_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  csws_req_if.sink                            in_req,
  csws_res_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [csws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csws_pkg::CFG_W-1:0]          cfg_wdata
);

  `include "counting_semaphore_wait_stack_macros.svh"

  localparam int DEPTH_W = $clog2(WAIT_DEPTH + 1);
  localparam int CMP_W   = (COUNT_BITS > csws_pkg::CFG_W) ? COUNT_BITS : csws_pkg::CFG_W;

  logic [COUNT_BITS-1:0]          count_r, count_nxt;
  logic [csws_pkg::CFG_W-1:0]     limit_r;
  logic [DEPTH_W-1:0]             depth_r, depth_nxt;
  logic                           out_valid_r;
  logic [csws_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [csws_pkg::PID_W-1:0]     woken_r, woken_nxt;

  logic                           in_ready;
  logic                           acc;
  logic [PID_BITS-1:0]            pid_in;
  logic                           stack_full;
  logic                           can_inc;
  csws_pkg::shift_t               shift;
  logic [PID_BITS-1:0]            cell_q [WAIT_DEPTH];

  // Output register frees up when empty or being drained
  assign in_ready      = !out_valid_r || out_res.ready;
  assign in_req.ready  = in_ready;
  assign acc           = in_req.valid && in_ready;
  assign pid_in        = PID_BITS'(in_req.pid);

  assign stack_full = (depth_r == DEPTH_W'(WAIT_DEPTH));
  assign can_inc    = (CMP_W'(count_r) < CMP_W'(limit_r)) && (count_r != '1);

  // Request decision
  always_comb begin
    count_nxt  = count_r;
    depth_nxt  = depth_r;
    shift      = '0;
    status_nxt = csws_pkg::ST_OVER_MAX;
    woken_nxt  = '0;
    if (in_req.operation == csws_pkg::OP_WAIT) begin
      if (count_r != '0) begin
        count_nxt  = count_r - COUNT_BITS'(1);
        status_nxt = csws_pkg::ST_GRANTED;
      end else if (!stack_full) begin
        shift.push = acc;
        depth_nxt  = depth_r + DEPTH_W'(1);
        status_nxt = csws_pkg::ST_QUEUED;
      end else begin
        status_nxt = csws_pkg::ST_FULL;
      end
    end else if (can_inc) begin
      count_nxt = count_r + COUNT_BITS'(1);
      if (depth_r != '0) begin
        shift.pop  = acc;
        depth_nxt  = depth_r - DEPTH_W'(1);
        status_nxt = csws_pkg::ST_WOKE;
        woken_nxt  = csws_pkg::PID_W'(cell_q[0]);
      end else begin
        status_nxt = csws_pkg::ST_SIGNALED;
      end
    end
  end

  // Waiter stack: chain of cells, top at index 0
  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    logic [PID_BITS-1:0] above;
    logic [PID_BITS-1:0] below;
    if (i == 0) begin : g_top
      assign above = pid_in;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == WAIT_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    csws_cell #(
      .PID_BITS (PID_BITS)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .pid_r      (cell_q[i])
    );
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      limit_r     <= csws_pkg::CFG_W'(1);
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == csws_pkg::CFG_LOAD_COUNT) begin
        count_r <= COUNT_BITS'(cfg_wdata);
      end else if (acc) begin
        count_r <= count_nxt;
      end
      if (cfg_we && cfg_index == csws_pkg::CFG_COUNT_LIMIT) begin
        limit_r <= cfg_wdata;
      end
      if (acc) begin
        depth_r <= depth_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      woken_r  <= woken_nxt;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.status    = status_r;
  assign out_res.woken_pid = woken_r;

  // Checks
  `CSWS_ASSERT_NEVER(a_depth_bound, depth_r > DEPTH_W'(WAIT_DEPTH),
    "waiter depth over capacity")
  `CSWS_ASSERT_NXT(a_acc_result, acc, out_valid_r, "accepted request left no result")
  `CSWS_ASSERT_NXT(a_push_depth, acc && status_nxt == csws_pkg::ST_QUEUED,
    depth_r == DEPTH_W'($past(depth_r) + DEPTH_W'(1)),
    "queued wait did not grow the stack")
  `CSWS_ASSERT_IMP(a_woke_nonempty, acc && status_nxt == csws_pkg::ST_WOKE,
    depth_r != '0, "woke a waiter from an empty stack")
  `CSWS_ASSERT_NXT(a_overmax_hold,
    acc && !cfg_we && status_nxt == csws_pkg::ST_OVER_MAX,
    $stable(count_r) && $stable(depth_r), "over-max signal changed state")

endmodule

// ===== rtl/csws_cell.sv =====
`timescale 1ns / 1ps

// One slot of the waiter stack. On push it takes the id from the cell above
// (closer to the top), on pop it takes the id from the cell below.
module csws_cell #(
  parameter int PID_BITS = csws_pkg::PID_BITS_DEF
) (
  input  logic                 clk,
  input  csws_pkg::shift_t     shift,
  input  logic [PID_BITS-1:0]  from_above,
  input  logic [PID_BITS-1:0]  from_below,
  output logic [PID_BITS-1:0]  pid_r
);

  logic [PID_BITS-1:0] pid_nxt;

  always_comb begin
    pid_nxt = pid_r;
    if (shift.push) begin
      pid_nxt = from_above;
    end else if (shift.pop) begin
      pid_nxt = from_below;
    end
  end

  // Stack contents need no reset
  always_ff @(posedge clk) begin
    pid_r <= pid_nxt;
  end

endmodule
